// File: sv/bnpv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnpv_pkg
// Shared constants and types of the banked nibble-pixel video RAM writer.
// ----------------------------------------------------------------------------
package bnpv_pkg;

	// RAM geometry; both counts are powers of two so the RAM address wraps
	// by truncation
	localparam int BANK_BYTES = 8192;
	localparam int BANK_COUNT = 32;
	localparam int RAM_BYTES  = BANK_BYTES * BANK_COUNT;
	localparam int BANK_AW    = $clog2(BANK_BYTES);
	localparam int RAM_AW     = $clog2(RAM_BYTES);

	// Field widths
	localparam int OFF_W   = 13;
	localparam int BSEL_W  = 5;
	localparam int PEN_W   = 8;
	localparam int PIX_AW  = 18;
	localparam int PIXB_W  = PIX_AW - 1;
	localparam int COLOR_W = 11;
	localparam int GRP_W   = 7;

	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_W  = $clog2(QDEPTH + 1);

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_BANK = 1'b0;
	localparam logic REG_PEN  = 1'b1;

	// Codes
	localparam logic OP_READ    = 1'b0;
	localparam logic OP_WRITE   = 1'b1;
	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;
	localparam logic [3:0] NIB_CLEAR = 4'hf;

	// One classified bus access
	typedef struct packed {
		logic              is_write;
		logic [RAM_AW-1:0] ram_addr;
		logic [PIXB_W-1:0] pix_base;
		logic [7:0]        data;
		logic              opaque;
		logic              layer;
		logic [GRP_W-1:0]  pen_grp;
	} bnpv_entry_t;

endpackage
`default_nettype wire

// File: sv/bnpv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnpv_front
// Accepts bus accesses, works out RAM and pixel addresses and the opaque
// mode, and keeps them in a short queue for the back end.
// ----------------------------------------------------------------------------
module bnpv_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          opcode,
	input  wire logic [bnpv_pkg::OFF_W-1:0]    bus_offset,
	input  wire logic [7:0]                    write_byte,
	input  wire logic [bnpv_pkg::BSEL_W-1:0]   bank_select,
	input  wire logic [bnpv_pkg::PEN_W-1:0]    pen_register,
	input  wire logic                          hold,
	output logic                               q_valid,
	input  wire logic                          q_pop,
	output bnpv_pkg::bnpv_entry_t              q_entry
);

	bnpv_pkg::bnpv_entry_t                 fifo_q [bnpv_pkg::QDEPTH];
	bnpv_pkg::bnpv_entry_t                 cls;
	logic [bnpv_pkg::PTR_W-1:0]            wr_ptr_q;
	logic [bnpv_pkg::PTR_W-1:0]            rd_ptr_q;
	logic [bnpv_pkg::CNT_W-1:0]            cnt_q;
	logic [31:0]                           ram_sum;
	logic [31:0]                           pix_sum;
	logic                                  push;

	// address arithmetic: bank times bank size plus offset (low 4 bank bits for pixels)
	assign ram_sum = (32'(bank_select) << bnpv_pkg::BANK_AW) + 32'(bus_offset);
	assign pix_sum = (32'(bank_select[3:0]) << bnpv_pkg::BANK_AW) + 32'(bus_offset);

	// classify the access
	always_comb begin
		cls.is_write = (opcode == bnpv_pkg::OP_WRITE);
		cls.ram_addr = ram_sum[bnpv_pkg::RAM_AW-1:0];
		cls.pix_base = pix_sum[bnpv_pkg::PIXB_W-1:0];
		cls.data     = write_byte;
		cls.opaque   = pen_register[7] | bank_select[4];
		cls.layer    = bank_select[4];
		cls.pen_grp  = pen_register[bnpv_pkg::GRP_W-1:0];
	end

	assign item_ready = !hold && (cnt_q != bnpv_pkg::CNT_W'(bnpv_pkg::QDEPTH));
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != '0);
	assign q_entry    = fifo_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == bnpv_pkg::PTR_W'(bnpv_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == bnpv_pkg::PTR_W'(bnpv_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/bnpv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnpv_back
// Owns the video RAM: clears it after reset, then reads each queued access,
// writes back merged writes and sends any words via an output register.
// ----------------------------------------------------------------------------
module bnpv_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	output logic                               q_pop,
	input  wire bnpv_pkg::bnpv_entry_t         q_entry,
	output logic                               clear_busy,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               result_kind,
	output logic [7:0]                         read_byte,
	output logic                               layer,
	output logic [bnpv_pkg::PIX_AW-1:0]        pixel_address,
	output logic [bnpv_pkg::COLOR_W-1:0]       pixel_color,
	output logic                               last
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_LOOK  = 4'b0100,
		ST_SEND  = 4'b1000
	} bnpv_state_t;

	logic [7:0]                   vram_mem [bnpv_pkg::RAM_BYTES];
	bnpv_state_t                  state_q;
	bnpv_state_t                  state_d;
	logic [bnpv_pkg::RAM_AW-1:0]  clr_cnt_q;
	bnpv_pkg::bnpv_entry_t        ent_q;
	logic [7:0]                   rd_data_q;
	logic [7:0]                   byte_q;
	logic                         pend_rd_q;
	logic                         pend_hi_q;
	logic                         pend_lo_q;
	logic                         out_valid_q;
	logic                         kind_q;
	logic [7:0]                   rbyte_q;
	logic                         layer_q;
	logic [bnpv_pkg::PIX_AW-1:0]  addr_q;
	logic [bnpv_pkg::COLOR_W-1:0] color_q;
	logic                         last_q;

	logic                         out_free;
	logic                         send_final;
	logic                         hi_clear;
	logic                         lo_clear;
	logic                         emit_hi;
	logic                         emit_lo;
	logic [7:0]                   stored;
	logic                         ram_we;
	logic [bnpv_pkg::RAM_AW-1:0]  ram_waddr;
	logic [7:0]                   ram_wdata;
	logic [bnpv_pkg::RAM_AW-1:0]  ram_raddr;

	// nibble merge against the old byte
	always_comb begin
		hi_clear = (ent_q.data[7:4] == bnpv_pkg::NIB_CLEAR);
		lo_clear = (ent_q.data[3:0] == bnpv_pkg::NIB_CLEAR);
		emit_hi  = ent_q.opaque || !hi_clear;
		emit_lo  = ent_q.opaque || !lo_clear;
		if (ent_q.opaque) begin
			stored = ent_q.data;
		end else begin
			stored = {hi_clear ? rd_data_q[7:4] : ent_q.data[7:4],
			          lo_clear ? rd_data_q[3:0] : ent_q.data[3:0]};
		end
	end

	// output register handshake
	assign out_free   = !out_valid_q || result_ready;
	assign send_final = (state_q == ST_SEND) && out_free && !(pend_hi_q && pend_lo_q);
	assign q_pop      = q_valid && ((state_q == ST_IDLE) || send_final);
	assign clear_busy = (state_q == ST_CLEAR);

	// RAM port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ent_q.ram_addr;
		ram_wdata = stored;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (state_q == ST_LOOK && ent_q.is_write) begin
			ram_we = 1'b1;
		end
		ram_raddr = q_pop ? q_entry.ram_addr : ent_q.ram_addr;
	end

	// video RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ram_we) begin
			vram_mem[ram_waddr] <= ram_wdata;
		end
		rd_data_q <= vram_mem[ram_raddr];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_valid) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (ent_q.is_write && !emit_hi && !emit_lo) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (send_final) begin
					state_d = q_valid ? ST_LOOK : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			pend_rd_q   <= 1'b0;
			pend_hi_q   <= 1'b0;
			pend_lo_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (state_q == ST_LOOK) begin
				pend_rd_q <= !ent_q.is_write;
				pend_hi_q <= ent_q.is_write && emit_hi;
				pend_lo_q <= ent_q.is_write && emit_lo;
			end else if (state_q == ST_SEND && out_free) begin
				if (pend_rd_q) begin
					pend_rd_q <= 1'b0;
				end else if (pend_hi_q) begin
					pend_hi_q <= 1'b0;
				end else begin
					pend_lo_q <= 1'b0;
				end
			end
			if (state_q == ST_SEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: current access and output word
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_entry;
		end
		if (state_q == ST_LOOK) begin
			byte_q <= ent_q.is_write ? stored : rd_data_q;
		end
		if (state_q == ST_SEND && out_free) begin
			if (pend_rd_q) begin
				kind_q  <= bnpv_pkg::KIND_READ;
				rbyte_q <= byte_q;
				layer_q <= 1'b0;
				addr_q  <= '0;
				color_q <= '0;
				last_q  <= 1'b1;
			end else if (pend_hi_q) begin
				kind_q  <= bnpv_pkg::KIND_PIXEL;
				rbyte_q <= '0;
				layer_q <= ent_q.layer;
				addr_q  <= {ent_q.pix_base, 1'b1};
				color_q <= {ent_q.pen_grp, byte_q[7:4]};
				last_q  <= !pend_lo_q;
			end else begin
				kind_q  <= bnpv_pkg::KIND_PIXEL;
				rbyte_q <= '0;
				layer_q <= ent_q.layer;
				addr_q  <= {ent_q.pix_base, 1'b0};
				color_q <= {ent_q.pen_grp, byte_q[3:0]};
				last_q  <= 1'b1;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign result_kind   = kind_q;
	assign read_byte     = rbyte_q;
	assign layer         = layer_q;
	assign pixel_address = addr_q;
	assign pixel_color   = color_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// File: sv/banked_nibble_pixel_vram_writer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// banked_nibble_pixel_vram_writer_core
// Banked video RAM with two 4-bit pixels per byte; bus writes update the RAM
// and are turned into framebuffer pixel writes.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Word
//  item      item_valid / item_ready        opcode, bus_offset, write_byte
//  result    result_valid / result_ready    result_kind, read_byte, layer,
//                                           pixel_address, pixel_color, last
//  config    psel / penable / pwrite        paddr, pwdata, prdata (pready = 1)
//
//  After reset the RAM is cleared one byte per cycle with item_ready low;
//  configuration writes are taken throughout.
//  Each access passes LOOK (merge and write-back for a write) and SEND,
//  which sends one word, or two for a two-pixel write, through the one-word
//  output register; a transparent write ends after LOOK.
//  A two-entry queue takes new items while the back end stalls on result_ready.
// ----------------------------------------------------------------------------
module banked_nibble_pixel_vram_writer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bnpv_pkg::APB_AW-1:0]   paddr,
	input  wire logic [bnpv_pkg::APB_DW-1:0]   pwdata,
	output logic [bnpv_pkg::APB_DW-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic                          opcode,
	input  wire logic [bnpv_pkg::OFF_W-1:0]    bus_offset,
	input  wire logic [7:0]                    write_byte,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               result_kind,
	output logic [7:0]                         read_byte,
	output logic                               layer,
	output logic [bnpv_pkg::PIX_AW-1:0]        pixel_address,
	output logic [bnpv_pkg::COLOR_W-1:0]       pixel_color,
	output logic                               last
);

	logic [bnpv_pkg::BSEL_W-1:0] bank_q;
	logic [bnpv_pkg::PEN_W-1:0]  pen_q;
	logic                        cfg_wr;
	logic                        q_valid;
	logic                        q_pop;
	logic                        clear_busy;
	bnpv_pkg::bnpv_entry_t       q_entry;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			pen_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[bnpv_pkg::APB_AW-1])
				bnpv_pkg::REG_BANK: bank_q <= pwdata[bnpv_pkg::BSEL_W-1:0];
				bnpv_pkg::REG_PEN:  pen_q  <= pwdata[bnpv_pkg::PEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[bnpv_pkg::APB_AW-1])
			bnpv_pkg::REG_BANK: prdata = bnpv_pkg::APB_DW'(bank_q);
			bnpv_pkg::REG_PEN:  prdata = bnpv_pkg::APB_DW'(pen_q);
			default:            prdata = '0;
		endcase
	end

	bnpv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.opcode       (opcode),
		.bus_offset   (bus_offset),
		.write_byte   (write_byte),
		.bank_select  (bank_q),
		.pen_register (pen_q),
		.hold         (clear_busy),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_entry      (q_entry)
	);

	bnpv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_pop         (q_pop),
		.q_entry       (q_entry),
		.clear_busy    (clear_busy),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.read_byte     (read_byte),
		.layer         (layer),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last          (last)
	);

	// no access enters while the RAM is being cleared
	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !item_ready)
		else $error("item accepted during RAM clear");

	// a read answers with one word only
	a_read_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_kind == bnpv_pkg::KIND_READ) |-> last)
		else $error("read result without last");

	// a high pixel that is not last is followed at once by its low pixel
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && !last) |=>
		(result_valid && last && result_kind == bnpv_pkg::KIND_PIXEL &&
		 !pixel_address[0]))
		else $error("low pixel did not follow high pixel");

endmodule
`default_nettype wire
